/* rtl/cbm_pkg.sv */
package cbm_pkg;

  localparam int PRG_BANKS_MAX_DEF = 256;
  localparam int CHR_BANKS_MAX_DEF = 2048;

  localparam int RAM_BYTES  = 8192;
  localparam int RAM_AW     = $clog2(RAM_BYTES);
  localparam int DIVIDEND_W = 15;
  localparam int DIVISOR_W  = 12;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int CFG_DATA_W = 12;
  localparam int TARGET_W   = 21;

  localparam logic [15:0] ADDR_SRAM_LO = 16'h6000;
  localparam logic [15:0] ADDR_SRAM_HI = 16'h7FFF;
  localparam logic [15:0] ADDR_PRG_LO  = 16'h8000;
  localparam logic [15:0] ADDR_PAT_HI  = 16'h1FFF;
  localparam logic [10:0] NT_HIGH_PAGE = 11'h400;

  typedef logic [3:0] op_t;
  localparam op_t OP_CPU_READ     = 4'd0;
  localparam op_t OP_CPU_WRITE    = 4'd1;
  localparam op_t OP_PAT_READ     = 4'd2;
  localparam op_t OP_PAT_WRITE    = 4'd3;
  localparam op_t OP_NT_MAP       = 4'd4;
  localparam op_t OP_PRG_8K       = 4'd5;
  localparam op_t OP_PRG_16K      = 4'd6;
  localparam op_t OP_PRG_32K      = 4'd7;
  localparam op_t OP_CHR_1K       = 4'd8;
  localparam op_t OP_CHR_2K       = 4'd9;
  localparam op_t OP_CHR_4K       = 4'd10;
  localparam op_t OP_CHR_8K       = 4'd11;
  localparam op_t OP_DEFAULT_BANK = 4'd12;

  typedef logic [2:0] mirror_t;
  localparam mirror_t MIR_HORIZONTAL = 3'd0;
  localparam mirror_t MIR_VERTICAL   = 3'd1;
  localparam mirror_t MIR_ONE_LOW    = 3'd3;
  localparam mirror_t MIR_ONE_HIGH   = 3'd4;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PRG_COUNT = 3'd0;
  localparam cfg_idx_t CFG_CHR_COUNT = 3'd1;
  localparam cfg_idx_t CFG_CHR_RAM   = 3'd2;
  localparam cfg_idx_t CFG_SRAM      = 3'd3;
  localparam cfg_idx_t CFG_MIRROR    = 3'd4;

  typedef struct packed {
    logic [3:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [2:0]  slot;
    logic [11:0] bank;
  } item_t;

  typedef struct packed {
    logic [7:0]          read_data;
    logic [TARGET_W-1:0] target_address;
    logic                rom_fetch;
    logic                accepted;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SETUP,
    ST_DIV,
    ST_FILL,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic mem_access;
    logic div_start;
    logic div_step;
    logic fill_step;
    logic next_run;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic bank_op;
    logic div_last;
    logic fill_last;
    logic last_run;
  } status_t;

endpackage

/* rtl/cbm_ctrl.sv */
module cbm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cbm_pkg::status_t status,
  output cbm_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);
  import cbm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.mem_access = 1'b1;
        state_next     = status.bank_op ? ST_SETUP : ST_RESP;
      end
      ST_SETUP: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          if (status.last_run) begin
            state_next = ST_RESP;
          end else begin
            cmd.next_run = 1'b1;
            state_next   = ST_SETUP;
          end
        end
      end
      ST_RESP: begin
        busy = 1'b0;
        done = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/cbm_datapath.sv */
module cbm_datapath #(
  parameter int PRG_BANKS_MAX = cbm_pkg::PRG_BANKS_MAX_DEF,
  parameter int CHR_BANKS_MAX = cbm_pkg::CHR_BANKS_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cbm_pkg::cmd_t                 cmd,
  output cbm_pkg::status_t              status,
  input  cbm_pkg::item_t                item_in,
  input  logic                          cfg_we,
  input  cbm_pkg::cfg_idx_t             cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data,
  output cbm_pkg::result_t              result
);
  import cbm_pkg::*;

  localparam int PRG_BW = $clog2(PRG_BANKS_MAX);
  localparam int CHR_BW = $clog2(CHR_BANKS_MAX);

  // configuration
  logic [8:0]  prg_count;
  logic [11:0] chr_count;
  logic        chr_ram_en;
  logic        sram_en;
  mirror_t     mirror;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_count  <= 9'd2;
      chr_count  <= 12'd8;
      chr_ram_en <= 1'b0;
      sram_en    <= 1'b0;
      mirror     <= MIR_HORIZONTAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRG_COUNT: prg_count  <= cfg_data[8:0];
        CFG_CHR_COUNT: chr_count  <= cfg_data[11:0];
        CFG_CHR_RAM:   chr_ram_en <= cfg_data[0];
        CFG_SRAM:      sram_en    <= cfg_data[0];
        CFG_MIRROR:    mirror     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [8:0]  prg_eff;
  logic [11:0] chr_eff;

  always_comb begin
    prg_eff = prg_count;
    if (prg_count == 9'd0) begin
      prg_eff = 9'd1;
    end else if (prg_count > 9'(PRG_BANKS_MAX)) begin
      prg_eff = 9'(PRG_BANKS_MAX);
    end
    chr_eff = chr_count;
    if (chr_count == 12'd0) begin
      chr_eff = 12'd1;
    end else if (chr_count > 12'(CHR_BANKS_MAX)) begin
      chr_eff = 12'(CHR_BANKS_MAX);
    end
  end

  // latched item
  item_t       itm;
  logic [15:0] a;
  op_t         op;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      itm <= item_in;
    end
  end

  assign a  = itm.address;
  assign op = itm.operation;

  // slot bank registers
  logic [PRG_BW-1:0] prg_bank [4];
  logic [CHR_BW-1:0] chr_bank [8];
  logic [PRG_BW-1:0] pbank;
  logic [CHR_BW-1:0] cbank;

  assign pbank = prg_bank[a[14:13]];
  assign cbank = chr_bank[a[12:10]];

  // access decode
  logic sram_hit;
  logic pat_ok;

  assign sram_hit = sram_en && (a >= ADDR_SRAM_LO) && (a <= ADDR_SRAM_HI);
  assign pat_ok   = (a <= ADDR_PAT_HI);

  // save ram and pattern ram, cleared by a sweep after reset
  logic [7:0]        save_ram    [RAM_BYTES];
  logic [7:0]        pattern_ram [RAM_BYTES];
  logic [7:0]        save_q, pat_q;
  logic [RAM_AW-1:0] clr_cnt;
  logic [RAM_AW-1:0] save_addr, pat_addr;
  logic [7:0]        wdata;
  logic              save_we, pat_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign save_addr = cmd.clear_step ? clr_cnt : a[RAM_AW-1:0];
  assign pat_addr  = cmd.clear_step ? clr_cnt : RAM_AW'({cbank, a[9:0]});
  assign wdata     = cmd.clear_step ? 8'd0 : itm.write_data;
  assign save_we   = cmd.clear_step || (cmd.mem_access && (op == OP_CPU_WRITE) && sram_hit);
  assign pat_we    = cmd.clear_step ||
                     (cmd.mem_access && (op == OP_PAT_WRITE) && pat_ok && chr_ram_en);

  always_ff @(posedge clk) begin
    if (save_we) begin
      save_ram[save_addr] <= wdata;
    end
    if (cmd.mem_access) begin
      save_q <= save_ram[save_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pattern_ram[pat_addr] <= wdata;
    end
    if (cmd.mem_access) begin
      pat_q <= pattern_ram[pat_addr];
    end
  end

  // bank select runs
  logic [1:0]            run_idx;
  logic                  run_chr;
  logic [2:0]            run_len_m1;
  logic [2:0]            run_base;
  logic [DIVIDEND_W-1:0] run_value;
  logic                  bank_op;
  logic                  last_run;
  logic [7:0]            n16;
  logic [7:0]            last16;

  assign n16    = prg_eff[8:1];
  assign last16 = (n16 == 8'd0) ? 8'd0 : n16 - 8'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      run_idx <= '0;
    end else if (cmd.next_run) begin
      run_idx <= run_idx + 2'd1;
    end
  end

  always_comb begin
    run_chr    = 1'b0;
    run_len_m1 = 3'd0;
    run_base   = 3'd0;
    run_value  = '0;
    bank_op    = 1'b1;
    last_run   = 1'b1;
    unique case (op)
      OP_PRG_8K: begin
        run_base  = {1'b0, itm.slot[1:0]};
        run_value = DIVIDEND_W'(itm.bank);
      end
      OP_PRG_16K: begin
        run_len_m1 = 3'd1;
        run_base   = {1'b0, itm.slot[0], 1'b0};
        run_value  = DIVIDEND_W'(itm.bank) << 1;
      end
      OP_PRG_32K: begin
        run_len_m1 = 3'd3;
        run_value  = DIVIDEND_W'(itm.bank) << 2;
      end
      OP_CHR_1K: begin
        run_chr   = 1'b1;
        run_base  = itm.slot;
        run_value = DIVIDEND_W'(itm.bank);
      end
      OP_CHR_2K: begin
        run_chr    = 1'b1;
        run_len_m1 = 3'd1;
        run_base   = {itm.slot[1:0], 1'b0};
        run_value  = DIVIDEND_W'(itm.bank) << 1;
      end
      OP_CHR_4K: begin
        run_chr    = 1'b1;
        run_len_m1 = 3'd3;
        run_base   = {itm.slot[0], 2'b00};
        run_value  = DIVIDEND_W'(itm.bank) << 2;
      end
      OP_CHR_8K: begin
        run_chr    = 1'b1;
        run_len_m1 = 3'd7;
        run_value  = DIVIDEND_W'(itm.bank) << 3;
      end
      OP_DEFAULT_BANK: begin
        last_run = (run_idx == 2'd2);
        case (run_idx)
          2'd0: begin
            run_len_m1 = 3'd1;
          end
          2'd1: begin
            run_len_m1 = 3'd1;
            run_base   = 3'd2;
            run_value  = DIVIDEND_W'({last16, 1'b0});
          end
          default: begin
            run_chr    = 1'b1;
            run_len_m1 = 3'd7;
          end
        endcase
      end
      default: begin
        bank_op = 1'b0;
      end
    endcase
  end

  // remainder unit, one quotient bit per step, then walk up through the run
  logic [DIVISOR_W-1:0]  divisor;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W:0]    rem_sh, rem_sub, rem_inc;
  logic [STEP_W-1:0]     step_cnt;
  logic [2:0]            fill_idx;
  logic [2:0]            slot_idx;

  assign divisor  = run_chr ? chr_eff : DIVISOR_W'(prg_eff);
  assign rem_sh   = {rem, quo[DIVIDEND_W-1]};
  assign rem_sub  = rem_sh - {1'b0, divisor};
  assign rem_inc  = {1'b0, rem} + 1'b1;
  assign slot_idx = run_base + fill_idx;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo      <= run_value;
      rem      <= '0;
      step_cnt <= '0;
      fill_idx <= '0;
    end else if (cmd.div_step) begin
      quo      <= quo << 1;
      step_cnt <= step_cnt + 1'b1;
      if (rem_sh >= {1'b0, divisor}) begin
        rem <= rem_sub[DIVISOR_W-1:0];
      end else begin
        rem <= rem_sh[DIVISOR_W-1:0];
      end
    end else if (cmd.fill_step) begin
      fill_idx <= fill_idx + 3'd1;
      rem      <= (rem_inc == {1'b0, divisor}) ? '0 : rem_inc[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank <= '{default: '0};
      chr_bank <= '{default: '0};
    end else if (cmd.fill_step) begin
      if (run_chr) begin
        chr_bank[slot_idx] <= rem[CHR_BW-1:0];
      end else begin
        prg_bank[slot_idx[1:0]] <= rem[PRG_BW-1:0];
      end
    end
  end

  assign status.clear_last = (clr_cnt == '1);
  assign status.bank_op    = bank_op;
  assign status.div_last   = (step_cnt == STEP_W'(DIV_STEPS - 1));
  assign status.fill_last  = (fill_idx == run_len_m1);
  assign status.last_run   = last_run;

  // result
  always_comb begin
    result = '0;
    unique case (op)
      OP_CPU_READ: begin
        if (a >= ADDR_PRG_LO) begin
          result.target_address = (TARGET_W'(pbank) << 13) | TARGET_W'(a[12:0]);
          result.rom_fetch      = 1'b1;
        end else if (sram_hit) begin
          result.read_data = save_q;
        end else begin
          result.read_data = a[15:8];
        end
      end
      OP_CPU_WRITE: begin
        result.accepted = sram_hit;
      end
      OP_PAT_READ: begin
        if (pat_ok) begin
          if (chr_ram_en) begin
            result.read_data = pat_q;
          end else begin
            result.target_address = (TARGET_W'(cbank) << 10) | TARGET_W'(a[9:0]);
            result.rom_fetch      = 1'b1;
          end
        end
      end
      OP_PAT_WRITE: begin
        result.accepted = pat_ok && chr_ram_en;
      end
      OP_NT_MAP: begin
        unique case (mirror)
          MIR_HORIZONTAL: result.target_address = TARGET_W'({a[11], a[9:0]});
          MIR_VERTICAL:   result.target_address = TARGET_W'(a[10:0]);
          MIR_ONE_LOW:    result.target_address = TARGET_W'(a[9:0]);
          MIR_ONE_HIGH:   result.target_address = TARGET_W'(NT_HIGH_PAGE | {1'b0, a[9:0]});
          default:        result.target_address = TARGET_W'(a);
        endcase
      end
      default: ;
    endcase
  end

endmodule

/* rtl/cartridge_bank_mapper.sv */
// Cartridge address mapper with program and pattern bank switching.
// Item channel: an item (operation, address, write data, slot, bank) is taken
// when start is high and busy is low. Its result appears on result for exactly
// one cycle with done high; the receiver cannot stall it and must take it then.
// Bus operations (reads, writes, nametable map, unused codes) pass through the
// registered ram access (EXEC) and then the result (RESP); a new item can be
// taken in the same cycle as that result is shown.
// Bank selects run through a shared remainder unit (setup, division steps),
// which then fills one slot per cycle; an 8K program select makes one run and
// the default-bank load makes three (two program runs and one pattern run).
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write it only while no item is in flight.
// Reset (rst, synchronous): configuration and slot banks return to their
// defaults, then both 8KB rams are swept to zero, one byte per cycle, with busy
// high, before the first item is taken.
module cartridge_bank_mapper #(
  parameter int PRG_BANKS_MAX = cbm_pkg::PRG_BANKS_MAX_DEF,
  parameter int CHR_BANKS_MAX = cbm_pkg::CHR_BANKS_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  cbm_pkg::item_t                 item,
  output logic                           busy,
  output logic                           done,
  output cbm_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  cbm_pkg::cfg_idx_t              cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cbm_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  cbm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  cbm_datapath #(
    .PRG_BANKS_MAX (PRG_BANKS_MAX),
    .CHR_BANKS_MAX (CHR_BANKS_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item_in   (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

/* rtl/cbm_checker.sv */
module cbm_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input cbm_pkg::result_t result
);

  // a taken item always occupies the block in the next cycle
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after taking an item");

  // a result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without preceding work");

  // results are never shown while the block reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");

  // a rom fetch never reports a stored write
  a_fetch_no_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.rom_fetch && result.accepted))
    else $error("rom fetch and accepted write together");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
